// File: design/b64d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int MAXRES = 3;

    localparam logic [7:0] CH_PAD = 8'h3D;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_marker;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic       doc_error;
        logic       run_last;
    } t_out;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_DATA  = 3'd1,
        PH_PAD2  = 3'd2,
        PH_TRAIL = 3'd3,
        PH_ERR   = 3'd4
    } t_phase;

    // next state and results of one character
    typedef struct packed {
        logic [1:0]              n;
        t_out [MAXRES-1:0]       res;
        t_phase                  phase;
        logic [1:0]              cnt;
        logic [17:0]             acc;
    } t_dec;

    // bit 6: is a symbol, bits 5:0: its value
    function automatic logic [6:0] sym_value(input logic [7:0] c);
        logic [6:0] r;
        r = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
               (c == 8'h0C) || (c == 8'h0B);
    endfunction

endpackage

`default_nettype wire

// File: design/b64d_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_decode
    import b64d_pkg::*;
(
    input  t_in         i_item,
    input  t_phase      i_phase,
    input  logic [1:0]  i_cnt,
    input  logic [17:0] i_acc,
    output t_dec        o_dec
);

    logic [6:0]  sv;
    logic        sym_ok;
    logic [5:0]  v;
    logic        sp;
    logic        is_pad;
    logic        doc_ok;
    logic [23:0] w;

    assign sv     = sym_value(i_item.in_char);
    assign sym_ok = sv[6];
    assign v      = sv[5:0];
    assign sp     = is_space(i_item.in_char);
    assign is_pad = (i_item.in_char == CH_PAD);
    assign doc_ok = (i_phase == PH_LEAD) || (i_phase == PH_TRAIL) ||
                    ((i_phase == PH_DATA) && (i_cnt == 2'd0));
    assign w      = {i_acc, v};

    always_comb begin
        o_dec       = '0;
        o_dec.phase = i_phase;
        o_dec.cnt   = i_cnt;
        o_dec.acc   = i_acc;
        if (i_item.end_marker) begin
            o_dec.n      = 2'd1;
            o_dec.res[0] = '{out_byte: 8'h00, is_status: 1'b1,
                             doc_error: !doc_ok, run_last: 1'b1};
            o_dec.phase  = PH_LEAD;
            o_dec.cnt    = 2'd0;
            o_dec.acc    = '0;
        end else begin
            unique case (i_phase)
                PH_LEAD: begin
                    if (!sp) begin
                        if (sym_ok) begin
                            o_dec.acc   = {12'd0, v};
                            o_dec.cnt   = 2'd1;
                            o_dec.phase = PH_DATA;
                        end else begin
                            o_dec.phase = PH_ERR;
                        end
                    end
                end
                PH_DATA: begin
                    if (sym_ok) begin
                        if (i_cnt == 2'd3) begin
                            // group complete: three bytes
                            o_dec.n      = 2'd3;
                            o_dec.res[0] = '{w[23:16], 1'b0, 1'b0, 1'b0};
                            o_dec.res[1] = '{w[15:8], 1'b0, 1'b0, 1'b0};
                            o_dec.res[2] = '{w[7:0], 1'b0, 1'b0, 1'b1};
                            o_dec.acc    = '0;
                            o_dec.cnt    = 2'd0;
                        end else begin
                            o_dec.acc = {i_acc[11:0], v};
                            o_dec.cnt = i_cnt + 2'd1;
                        end
                    end else if (sp) begin
                        o_dec.phase = (i_cnt == 2'd0) ? PH_TRAIL : PH_ERR;
                    end else if (is_pad && i_cnt == 2'd3 && i_acc[1:0] == 2'd0) begin
                        // single pad: two bytes
                        o_dec.n      = 2'd2;
                        o_dec.res[0] = '{i_acc[17:10], 1'b0, 1'b0, 1'b0};
                        o_dec.res[1] = '{i_acc[9:2], 1'b0, 1'b0, 1'b1};
                        o_dec.acc    = '0;
                        o_dec.cnt    = 2'd0;
                        o_dec.phase  = PH_TRAIL;
                    end else if (is_pad && i_cnt == 2'd2 && i_acc[3:0] == 4'd0) begin
                        o_dec.phase = PH_PAD2;
                    end else begin
                        o_dec.phase = PH_ERR;
                    end
                end
                PH_PAD2: begin
                    if (is_pad) begin
                        o_dec.n      = 2'd1;
                        o_dec.res[0] = '{i_acc[11:4], 1'b0, 1'b0, 1'b1};
                        o_dec.acc    = '0;
                        o_dec.cnt    = 2'd0;
                        o_dec.phase  = PH_TRAIL;
                    end else begin
                        o_dec.phase = PH_ERR;
                    end
                end
                PH_TRAIL: begin
                    if (!sp) begin
                        o_dec.phase = PH_ERR;
                    end
                end
                PH_ERR: begin
                    o_dec.phase = PH_ERR;
                end
                default: begin
                    o_dec.phase = PH_ERR;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/b64d_resq.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_resq
    import b64d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_n,
    input  t_out [MAXRES-1:0] i_push_res,
    output logic [QAW:0]      o_cnt,
    output logic              o_valid,
    output t_out              o_head,
    input  logic              i_ready
);

    t_out           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;
    logic           pop;

    assign pop     = (r_cnt != '0) && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign o_cnt   = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + QAW'(i_push_n);
            r_rd  <= r_rd + QAW'(pop);
            r_cnt <= r_cnt + (QAW+1)'(i_push_n) - (QAW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAXRES; k++) begin
            if (2'(k) < i_push_n) begin
                r_mem[r_wr + QAW'(k)] <= i_push_res[k];
            end
        end
    end

endmodule

`default_nettype wire

// File: design/base64_decoder_strict_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Strict streaming Base64 decoder. One character word enters per cycle on the
// input channel while o_in_ready is high; the end_marker bit closes a
// document and returns one status word (is_status = 1, doc_error = 1 when
// the document was malformed), after which the decoder is back in its reset
// state for the next document. Data words carry one decoded byte each; a
// complete group of four symbols gives three bytes, a group closed by '='
// gives two and one closed by '==' gives one, and run_last marks the final
// word caused by each character. Bytes are streamed as they decode, so a
// consumer must drop everything of a document whose status reports an error.
// A character passes the input register, then the decode logic into a
// four-entry result queue. The input side takes one character per cycle
// while the queue has room for the words the held character produces; the
// queue drains one word per cycle while the output is taken, so a stream of
// well-formed groups (three bytes per four characters) runs at full rate
// when the output is taken every cycle.
module base64_decoder_strict_top
    import b64d_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // input register
    logic        r_in_vld;
    t_in         r_in;

    // decoder state
    t_phase      r_phase;
    logic [1:0]  r_cnt;
    logic [17:0] r_acc;

    t_dec        n_dec;
    logic [QAW:0]   q_cnt;
    logic [QAW+1:0] need;
    logic           proc;
    logic [1:0]     push_n;

    // next state and result words for the held character
    b64d_decode u_decode (
        .i_item  (r_in),
        .i_phase (r_phase),
        .i_cnt   (r_cnt),
        .i_acc   (r_acc),
        .o_dec   (n_dec)
    );

    // the held character retires only once all of its words fit in the queue
    assign need       = (QAW+2)'(q_cnt) + (QAW+2)'(n_dec.n);
    assign proc       = r_in_vld && (need <= (QAW+2)'(QDEPTH));
    assign push_n     = proc ? n_dec.n : 2'd0;
    // input register frees up in the same cycle its word retires
    assign o_in_ready = !r_in_vld || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_phase  <= PH_LEAD;
            r_cnt    <= 2'd0;
            r_acc    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            // state advances only when the held character retires
            if (proc) begin
                r_phase <= n_dec.phase;
                r_cnt   <= n_dec.cnt;
                r_acc   <= n_dec.acc;
            end
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // result queue, also acts as the output register
    b64d_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_n   (push_n),
        .i_push_res (n_dec.res),
        .o_cnt      (q_cnt),
        .o_valid    (o_out_valid),
        .o_head     (o_out_data),
        .i_ready    (i_out_ready)
    );

endmodule

`default_nettype wire

// File: design/b64d_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_checker
    import b64d_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // a stalled input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input word changed under stall");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed under stall");

    // a status word closes its character and carries no byte
    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_status |->
            o_out_data.run_last && (o_out_data.out_byte == 8'h00))
        else $error("malformed status word");

    // a data word never flags an error
    a_data_noerr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.is_status |-> !o_out_data.doc_error)
        else $error("error flag on data word");

    // no result word in the first cycle after reset
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result word right after reset");

endmodule

bind base64_decoder_strict_top b64d_checker u_b64d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import b64d_pkg::*;

    // one row of the directed table; nfix < 0 means the predictor decides
    typedef struct {
        t_in  word;
        int   nfix;
        t_out fix [3];
    } t_stim_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic in_valid    = 1'b0;
    t_in  in_data     = '0;
    logic out_ready   = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    // predictor state
    t_phase      dec_phase = PH_LEAD;
    logic [1:0]  dec_count = '0;
    logic [17:0] dec_acc   = '0;
    logic [6:0]  sym_lut [256];
    string       b64_alpha =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    t_out        awaited_words [$];
    t_in         doc_chars [$];
    t_stim_row   stim_table [$];
    int          mismatches = 0;
    int          burst_left = 0;
    logic [7:0]  stall_tick = '0;

    base64_decoder_strict_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hard stop in case the decoder hangs
    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    function automatic t_out data_word(input logic [7:0] b, input logic last);
        return '{out_byte: b, is_status: 1'b0, doc_error: 1'b0, run_last: last};
    endfunction

    function automatic t_out status_word(input logic err);
        return '{out_byte: 8'h00, is_status: 1'b1, doc_error: err, run_last: 1'b1};
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        case (c)
            8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C, 8'h0B: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // one character through the predictor; expected words go to the queue
    task automatic decode_step(input t_in w);
        logic [6:0]  code;
        logic        blank;
        logic        ok;
        logic [23:0] grp;
        int          n0;
        n0 = awaited_words.size();
        code = sym_lut[w.in_char];
        blank = is_blank(w.in_char);
        if (w.end_marker) begin
            // the document is fine only between whole groups or in whitespace
            ok = (dec_phase == PH_LEAD) || (dec_phase == PH_TRAIL) ||
                 (dec_phase == PH_DATA && dec_count == 2'd0);
            awaited_words.push_back(status_word(!ok));
            dec_phase = PH_LEAD;
            dec_count = '0;
            dec_acc   = '0;
        end else begin
            case (dec_phase)
                PH_LEAD: begin
                    if (!blank) begin
                        if (code[6]) begin
                            dec_acc   = {12'd0, code[5:0]};
                            dec_count = 2'd1;
                            dec_phase = PH_DATA;
                        end else begin
                            dec_phase = PH_ERR;
                        end
                    end
                end
                PH_DATA: begin
                    if (code[6]) begin
                        if (dec_count == 2'd3) begin
                            // fourth symbol closes the group: three bytes
                            grp = {dec_acc, code[5:0]};
                            awaited_words.push_back(data_word(grp[23:16], 1'b0));
                            awaited_words.push_back(data_word(grp[15:8], 1'b0));
                            awaited_words.push_back(data_word(grp[7:0], 1'b0));
                            dec_acc   = '0;
                            dec_count = '0;
                        end else begin
                            dec_acc   = {dec_acc[11:0], code[5:0]};
                            dec_count = dec_count + 2'd1;
                        end
                    end else if (blank) begin
                        dec_phase = (dec_count == 2'd0) ? PH_TRAIL : PH_ERR;
                    end else if (w.in_char == CH_PAD && dec_count == 2'd3 &&
                                 dec_acc[1:0] == 2'b00) begin
                        // single pad: two bytes from three symbols
                        awaited_words.push_back(data_word(dec_acc[17:10], 1'b0));
                        awaited_words.push_back(data_word(dec_acc[9:2], 1'b0));
                        dec_acc   = '0;
                        dec_count = '0;
                        dec_phase = PH_TRAIL;
                    end else if (w.in_char == CH_PAD && dec_count == 2'd2 &&
                                 dec_acc[3:0] == 4'h0) begin
                        dec_phase = PH_PAD2;
                    end else begin
                        dec_phase = PH_ERR;
                    end
                end
                PH_PAD2: begin
                    if (w.in_char == CH_PAD) begin
                        awaited_words.push_back(data_word(dec_acc[11:4], 1'b0));
                        dec_acc   = '0;
                        dec_count = '0;
                        dec_phase = PH_TRAIL;
                    end else begin
                        dec_phase = PH_ERR;
                    end
                end
                PH_TRAIL: begin
                    if (!blank) dec_phase = PH_ERR;
                end
                default: ;
            endcase
        end
        if (awaited_words.size() > n0) begin
            awaited_words[awaited_words.size() - 1].run_last = 1'b1;
        end
    endtask

    task automatic add_row(input logic [7:0] c, input logic e, input int n,
                           input t_out a = '0, input t_out b = '0, input t_out d = '0);
        t_stim_row r;
        r.word   = '{in_char: c, end_marker: e};
        r.nfix   = n;
        r.fix[0] = a;
        r.fix[1] = b;
        r.fix[2] = d;
        stim_table.push_back(r);
    endtask

    // present one word, with a random gap between bursts
    task automatic send_word(input t_in w);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 5))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0A;
            3: return 8'h0D;
            4: return 8'h0C;
            default: return 8'h0B;
        endcase
    endfunction

    task automatic push_char(input logic [7:0] c);
        doc_chars.push_back('{in_char: c, end_marker: 1'b0});
    endtask

    // one random document, mostly well formed, closed by an end marker
    task automatic build_doc();
        int         kind;
        int         pos;
        logic [5:0] v;
        doc_chars.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // noise: arbitrary bytes
            repeat ($urandom_range(1, 8)) push_char(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) push_char(blank_char());
            repeat ($urandom_range(0, 3)) begin
                repeat (4) push_char(b64_alpha[$urandom_range(0, 63)]);
            end
            case ($urandom_range(0, 2))
                1: begin
                    repeat (2) push_char(b64_alpha[$urandom_range(0, 63)]);
                    v = 6'($urandom_range(0, 63));
                    // mostly legal unused bits, sometimes not
                    if ($urandom_range(0, 7) != 0) v[1:0] = 2'b00;
                    push_char(b64_alpha[v]);
                    push_char(CH_PAD);
                end
                2: begin
                    push_char(b64_alpha[$urandom_range(0, 63)]);
                    v = 6'($urandom_range(0, 63));
                    if ($urandom_range(0, 7) != 0) v[3:0] = 4'h0;
                    push_char(b64_alpha[v]);
                    push_char(CH_PAD);
                    push_char(CH_PAD);
                end
                default: ;
            endcase
            repeat ($urandom_range(0, 2)) push_char(blank_char());
            // break a few documents on purpose
            if (kind >= 8 && doc_chars.size() > 0) begin
                pos = $urandom_range(0, doc_chars.size() - 1);
                case ($urandom_range(0, 3))
                    0: doc_chars[pos].in_char = 8'($urandom_range(0, 255));
                    1: doc_chars[pos].in_char = blank_char();
                    2: doc_chars[pos].in_char = CH_PAD;
                    default: while (doc_chars.size() > pos) void'(doc_chars.pop_back());
                endcase
            end
        end
        doc_chars.push_back('{in_char: 8'($urandom_range(0, 255)), end_marker: 1'b1});
    endtask

    // receiver stalls, mode chosen by the top two bits of a free-running tick counter
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 8'd1;
        case (stall_tick[7:6])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= 1'($urandom_range(0, 1));
            2'd2: out_ready <= (stall_tick[3:0] > 4'd5);
            default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // compare every accepted word with the oldest expected one
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (awaited_words.size() == 0) begin
                note_mismatch($sformatf("unexpected word %h", o_out_data));
            end else begin
                want = awaited_words.pop_front();
                if (o_out_data.out_byte !== want.out_byte)
                    note_mismatch($sformatf("out_byte %h, expected %h",
                                            o_out_data.out_byte, want.out_byte));
                if (o_out_data.is_status !== want.is_status)
                    note_mismatch($sformatf("is_status %b, expected %b",
                                            o_out_data.is_status, want.is_status));
                if (o_out_data.doc_error !== want.doc_error)
                    note_mismatch($sformatf("doc_error %b, expected %b",
                                            o_out_data.doc_error, want.doc_error));
                if (o_out_data.run_last !== want.run_last)
                    note_mismatch($sformatf("run_last %b, expected %b",
                                            o_out_data.run_last, want.run_last));
            end
        end
    end

    initial begin
        int n0;
        int sent;
        int guard;
        // symbol lookup from the alphabet
        for (int i = 0; i < 256; i++) sym_lut[i] = 7'd0;
        for (int v = 0; v < 64; v++) sym_lut[b64_alpha[v]] = {1'b1, 6'(v)};

        // empty document straight after reset
        add_row(8'h00, 1'b1, 1, status_word(1'b0));
        // leading blank, one full group decoding to "Man", trailing blank
        add_row(" ", 1'b0, 0);
        add_row("T", 1'b0, 0);
        add_row("W", 1'b0, 0);
        add_row("F", 1'b0, 0);
        add_row("u", 1'b0, 3, data_word(8'h4D, 1'b0), data_word(8'h61, 1'b0),
                data_word(8'h6E, 1'b1));
        add_row(8'h09, 1'b0, 0);
        add_row(8'hFF, 1'b1, 1, status_word(1'b0));
        // top symbols with a single pad
        add_row("/", 1'b0, -1);
        add_row("+", 1'b0, -1);
        add_row("8", 1'b0, -1);
        add_row(CH_PAD, 1'b0, -1);
        add_row(8'h00, 1'b1, 1, status_word(1'b0));
        // leading blank, then a lone symbol left open at the end
        add_row(8'h0B, 1'b0, 0);
        add_row("A", 1'b0, 0);
        add_row(8'h00, 1'b1, 1, status_word(1'b1));
        // double pad, then a blank
        add_row("z", 1'b0, -1);
        add_row("w", 1'b0, -1);
        add_row(CH_PAD, 1'b0, -1);
        add_row(CH_PAD, 1'b0, -1);
        add_row(8'h0D, 1'b0, 0);
        add_row(8'h00, 1'b1, 1, status_word(1'b0));
        // illegal character in the leading phase
        add_row(8'hFF, 1'b0, 0);
        add_row(8'h00, 1'b1, 1, status_word(1'b1));
        // end inside a group
        add_row("Q", 1'b0, 0);
        add_row(8'h00, 1'b1, 1, status_word(1'b1));

        // synchronous reset
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: typed rows replace what the predictor would say
        foreach (stim_table[r]) begin
            send_word(stim_table[r].word);
            n0 = awaited_words.size();
            decode_step(stim_table[r].word);
            if (stim_table[r].nfix >= 0) begin
                while (awaited_words.size() > n0) void'(awaited_words.pop_back());
                for (int k = 0; k < stim_table[r].nfix; k++)
                    awaited_words.push_back(stim_table[r].fix[k]);
            end
        end

        // random documents
        sent = 0;
        while (sent < 280) begin
            build_doc();
            foreach (doc_chars[k]) begin
                send_word(doc_chars[k]);
                decode_step(doc_chars[k]);
                sent++;
            end
        end
        in_valid <= 1'b0;

        // drain, then wait for stray words
        guard = 0;
        while (awaited_words.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (awaited_words.size() != 0)
            note_mismatch($sformatf("%0d expected words never came",
                                    awaited_words.size()));

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
